### sv/positional_pid_step_core_defines.svh
// Assertion helpers for the checker file.
`ifndef POSITIONAL_PID_STEP_CORE_DEFINES_SVH
`define POSITIONAL_PID_STEP_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define PPS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pps check failed: same-cycle implication");

// Next-cycle implication, off while reset is high.
`define PPS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pps check failed: next-cycle implication");

// Implication that also holds across reset.
`define PPS_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("pps check failed: reset behavior");

`endif

### sv/pps_pkg.sv
`timescale 1ns / 1ps
package pps_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ERR_W    = 17;
   localparam int LIMIT_W  = 17;
   localparam int CLAMP_W  = 31;
   localparam int GAIN_W   = 16;
   localparam int ACC_W    = 32;
   localparam int DRIVE_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ERROR_LIMIT      = 3'd0,
      CSR_DEADBAND         = 3'd1,
      CSR_SEPARATION_LIMIT = 3'd2,
      CSR_OUTPUT_LIMIT     = 3'd3,
      CSR_INTEGRAL_CLAMP   = 3'd4,
      CSR_GAIN_P           = 3'd5,
      CSR_GAIN_I           = 3'd6,
      CSR_GAIN_D           = 3'd7
   } csr_index_type;

   localparam logic REQ_COMPUTE = 1'b0;
   localparam logic REQ_CLEAR   = 1'b1;

   typedef struct packed {
      logic [LIMIT_W-1:0] error_limit;
      logic [LIMIT_W-1:0] deadband;
      logic [LIMIT_W-1:0] separation_limit;
      logic [CLAMP_W-1:0] output_limit;
      logic [CLAMP_W-1:0] integral_clamp;
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
   } cfg_type;

   typedef struct packed {
      logic                       req_type;
      logic signed [SAMPLE_W-1:0] measured;
      logic signed [SAMPLE_W-1:0] target;
   } req_item_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      out_of_range;
      logic signed [ERR_W-1:0]   prev_error;
      logic signed [ACC_W-1:0]   integral_acc;
   } calc_out_type;

endpackage

### sv/pps_if.sv
`timescale 1ns / 1ps
interface pps_req_if;
   import pps_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic signed [SAMPLE_W-1:0] measured;
   logic signed [SAMPLE_W-1:0] target;
   modport source (output valid, req_type, measured, target, input ready);
   modport sink   (input valid, req_type, measured, target, output ready);
endinterface

interface pps_rsp_if;
   import pps_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic                      out_of_range;
   modport source (output valid, drive, out_of_range, input ready);
   modport sink   (input valid, drive, out_of_range, output ready);
endinterface

interface pps_csr_if;
   import pps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/positional_pid_step_core.sv
`timescale 1ns / 1ps
// Positional PID step with error limit, deadband and integral separation.
//
// Channels: req_if carries one item per transfer (req_type selects a compute
// step or a clear, measured and target are signed 16-bit samples). rsp_if
// returns exactly one result per request: the clamped 32-bit drive and the
// out_of_range flag. csr_if writes the eight gain and limit registers by
// index; it is always ready and takes effect on the next cycle.
//
// Flow: a request taken by req_if is registered in the input stage, evaluated
// and written to the result register once that register is free or draining,
// so rsp_if.valid rises after that write and the result transfers while
// rsp_if.ready is high.
// Throughput: one item per cycle while rsp_if.ready is high. The controller
// state (previous error and integral) is updated in the same edge that loads
// the result register, so each item sees the state left by the item before it.
//
// Reset: both stages empty, previous error and integral zero, output limit
// and integral clamp at 32767, gains and thresholds zero.
// Stall: while rsp_if.ready is low the result holds; the input stage still
// takes one more item and then ready drops until the result drains.
module positional_pid_step_core (
   input  logic     clock,
   input  logic     reset,
   pps_req_if.sink  req_if,
   pps_rsp_if.source rsp_if,
   pps_csr_if.sink  csr_if
);
   import pps_pkg::*;

   cfg_type               cfg;
   calc_out_type          calc_out;

   // input stage
   logic                  stg_valid_ff;
   logic                  stg_valid_in;
   req_item_type          stg_item_ff;

   // result stage
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic                  out_of_range_ff;

   // controller state
   logic signed [ERR_W-1:0] prev_error_ff;
   logic signed [ERR_W-1:0] prev_error_in;
   logic signed [ACC_W-1:0] integral_ff;
   logic signed [ACC_W-1:0] integral_in;

   logic                  take_req;
   logic                  advance;

   pps_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   pps_calc u_calc (
      .cfg        (cfg),
      .item       (stg_item_ff),
      .last_error (prev_error_ff),
      .integral   (integral_ff),
      .result     (calc_out)
   );

   // Advance the input stage whenever the result register is free or draining.
   assign advance      = stg_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !stg_valid_ff || advance;
   assign take_req     = req_if.valid && req_if.ready;

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (take_req) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Commit state only when the item moves into the result register.
      prev_error_in = advance ? calc_out.prev_error   : prev_error_ff;
      integral_in   = advance ? calc_out.integral_acc : integral_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         stg_valid_ff  <= stg_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (take_req) begin
         stg_item_ff.req_type <= req_if.req_type;
         stg_item_ff.measured <= req_if.measured;
         stg_item_ff.target   <= req_if.target;
      end
      if (advance) begin
         drive_ff        <= calc_out.drive;
         out_of_range_ff <= calc_out.out_of_range;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.drive        = drive_ff;
   assign rsp_if.out_of_range = out_of_range_ff;

endmodule

### sv/pps_csr.sv
`timescale 1ns / 1ps
module pps_csr (
   input  logic             clock,
   input  logic             reset,
   pps_csr_if.sink          csr_if,
   output pps_pkg::cfg_type cfg
);
   import pps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_if.ready = 1'b1;
   assign write        = csr_if.valid;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_ERROR_LIMIT:      cfg_in.error_limit      = csr_if.data[LIMIT_W-1:0];
            CSR_DEADBAND:         cfg_in.deadband         = csr_if.data[LIMIT_W-1:0];
            CSR_SEPARATION_LIMIT: cfg_in.separation_limit = csr_if.data[LIMIT_W-1:0];
            CSR_OUTPUT_LIMIT:     cfg_in.output_limit     = csr_if.data[CLAMP_W-1:0];
            CSR_INTEGRAL_CLAMP:   cfg_in.integral_clamp   = csr_if.data[CLAMP_W-1:0];
            CSR_GAIN_P:           cfg_in.gain_p           = csr_if.data[GAIN_W-1:0];
            CSR_GAIN_I:           cfg_in.gain_i           = csr_if.data[GAIN_W-1:0];
            CSR_GAIN_D:           cfg_in.gain_d           = csr_if.data[GAIN_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{error_limit: '0, deadband: '0, separation_limit: '0,
                     output_limit: CLAMP_W'(32767), integral_clamp: CLAMP_W'(32767),
                     gain_p: '0, gain_i: '0, gain_d: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/pps_calc.sv
`timescale 1ns / 1ps
module pps_calc (
   input  pps_pkg::cfg_type                     cfg,
   input  pps_pkg::req_item_type                item,
   input  logic signed [pps_pkg::ERR_W-1:0]     last_error,
   input  logic signed [pps_pkg::ACC_W-1:0]     integral,
   output pps_pkg::calc_out_type                result
);
   import pps_pkg::*;

   logic signed [ERR_W-1:0]   err_raw;
   logic        [ERR_W-1:0]   mag_raw;
   logic                      over;
   logic                      dead;
   logic signed [ERR_W-1:0]   err;
   logic        [ERR_W-1:0]   mag_err;
   logic                      sep;
   logic signed [ERR_W:0]     diff;
   logic signed [33:0]        prod_p;
   logic signed [33:0]        prod_i;
   logic signed [34:0]        prod_d;
   logic signed [25:0]        p_term;
   logic signed [25:0]        i_term;
   logic signed [26:0]        d_term;
   logic signed [ACC_W:0]     i_sum;
   logic signed [ACC_W:0]     i_lim;
   logic signed [ACC_W-1:0]   i_new;
   logic signed [33:0]        total;
   logic signed [33:0]        o_lim;
   logic signed [DRIVE_W-1:0] drive_c;

   always_comb begin
      err_raw = {item.target[SAMPLE_W-1], item.target}
              - {item.measured[SAMPLE_W-1], item.measured};
      mag_raw = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
      over    = (cfg.error_limit != '0) && (mag_raw > cfg.error_limit);
      dead    = (cfg.deadband != '0) && (mag_raw < cfg.deadband);
      err     = dead ? '0 : err_raw;
      mag_err = dead ? '0 : mag_raw;
      sep     = (cfg.separation_limit != '0) && (mag_err > cfg.separation_limit);

      // Q8.8 gains; dropping the low byte of a two's complement value is a floor
      prod_p = $signed({1'b0, cfg.gain_p}) * err;
      prod_i = $signed({1'b0, cfg.gain_i}) * err;
      diff   = {err[ERR_W-1], err} - {last_error[ERR_W-1], last_error};
      prod_d = $signed({1'b0, cfg.gain_d}) * diff;
      p_term = prod_p[33:8];
      i_term = prod_i[33:8];
      d_term = prod_d[34:8];

      i_sum = {integral[ACC_W-1], integral} + {{7{i_term[25]}}, i_term};
      if (sep) begin
         i_sum = '0;
      end
      i_lim = $signed({2'b00, cfg.integral_clamp});
      if (i_sum > i_lim) begin
         i_new = i_lim[ACC_W-1:0];
      end else if (i_sum < -i_lim) begin
         i_new = ACC_W'(-i_lim);
      end else begin
         i_new = i_sum[ACC_W-1:0];
      end

      total = {{8{p_term[25]}}, p_term} + {{2{i_new[ACC_W-1]}}, i_new}
            + {{7{d_term[26]}}, d_term};
      o_lim = $signed({3'b000, cfg.output_limit});
      if (total > o_lim) begin
         drive_c = o_lim[DRIVE_W-1:0];
      end else if (total < -o_lim) begin
         drive_c = DRIVE_W'(-o_lim);
      end else begin
         drive_c = total[DRIVE_W-1:0];
      end

      if (item.req_type == REQ_CLEAR) begin
         result.drive        = '0;
         result.out_of_range = 1'b0;
         result.prev_error   = '0;
         result.integral_acc = '0;
      end else if (over) begin
         // keep the raw error, hold the integral
         result.drive        = '0;
         result.out_of_range = 1'b1;
         result.prev_error   = err_raw;
         result.integral_acc = integral;
      end else begin
         result.drive        = drive_c;
         result.out_of_range = 1'b0;
         result.prev_error   = err;
         result.integral_acc = i_new;
      end
   end

endmodule

### sv/pps_checker.sv
`timescale 1ns / 1ps
`include "positional_pid_step_core_defines.svh"
module pps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [pps_pkg::DRIVE_W-1:0] drive,
   input logic                               out_of_range
);
   import pps_pkg::*;

   // a stalled result holds
   `PPS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(drive) && $stable(out_of_range))
   // out of range always comes with zero drive
   `PPS_ASSERT_IMP(a_oor_zero, rsp_valid && out_of_range, drive == '0)
   // the symmetric clamp never reaches the most negative code
   `PPS_ASSERT_IMP(a_clamp_sym, rsp_valid, drive != {1'b1, {(DRIVE_W-1){1'b0}}})
   // no result right after reset
   `PPS_ASSERT_RST(a_rst_empty, $past(reset) == 1'b1, !rsp_valid)

endmodule

bind positional_pid_step_core pps_checker u_pps_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .drive        (rsp_if.drive),
   .out_of_range (rsp_if.out_of_range)
);
